### rtl/core/rlwc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlwc_pkg
// Types, constants and the run code builder for the run-length Wyle coder.
// ----------------------------------------------------------------------------
package rlwc_pkg;

    localparam int unsigned CODE_W    = 40;  // longest run code is 39 bits
    localparam int unsigned CLEN_W    = 6;
    localparam int unsigned STREAM_W  = 64;  // pending bits plus two run codes
    localparam int unsigned NBITS_W   = 7;
    localparam int unsigned HDR_W     = 32;
    localparam int unsigned OBUF_W    = STREAM_W + HDR_W;
    localparam int unsigned OCNT_W    = 4;
    localparam int unsigned HDR_BYTES = 4;

    typedef struct packed {
        logic [CODE_W-1:0] bits;  // first bit at the top
        logic [CLEN_W-1:0] len;
    } t_run_code;

    // Wyle code of a = run-1: L ones, a zero, L+2 low bits of a LSB first,
    // then the byte value MSB first. L is the bit length of a/4.
    function automatic t_run_code run_code(input logic [15:0] a, input logic [7:0] value);
        t_run_code         c;
        logic [13:0]       q;
        logic [3:0]        l;
        logic [15:0]       rev;
        logic [4:0]        rev_sh;
        logic [4:0]        val_sh;
        q = a[15:2];
        l = 4'd0;
        for (int i = 0; i < 14; i++) begin
            if (q[i]) begin
                l = 4'(i + 1);
            end
        end
        for (int i = 0; i < 16; i++) begin
            rev[15-i] = a[i];
        end
        rev_sh = {1'b0, l} + 5'd1;
        val_sh = {l, 1'b0} + 5'd3;
        c.bits = ~({CODE_W{1'b1}} >> l)
               | ({rev, 24'd0} >> rev_sh)
               | ({value, 32'd0} >> val_sh);
        c.len  = {1'b0, l, 1'b0} + 6'd11;
        return c;
    endfunction

endpackage

### rtl/core/run_length_wyle_coder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// run_length_wyle_coder
// Byte-stream run-length coder with Wyle-coded run lengths and a length header.
// ----------------------------------------------------------------------------
// An input transaction is registered, then coded into a byte buffer that
// drains one output byte per cycle while m_axis_tready is high. A byte that
// only extends the open run produces no output, so such bytes stream at one
// per cycle once the buffer is empty. A byte that closes a run (or ends the
// stream) yields 1 to 8 output bytes; the first item of a stream adds the 4
// header bytes to its own (up to 6 in all). The next input is coded in the
// cycle its last byte leaves, so an item holds the block until all of its
// output bytes have left. The output port, one byte per cycle, sets the
// sustained rate. The first item of a stream emits total_length as a
// 4-byte big-endian header; the last byte of every item's output carries
// tlast. total_length is written on the config channel, which is always ready.
module run_length_wyle_coder #(
    parameter int unsigned RUN_LIMIT = 65535
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [31:0] i_cfg_data,     // total_length
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tlast,   // is_last
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] out_byte
    output logic        m_axis_tlast    // out_last
);

    localparam logic [15:0] LIMIT = 16'(RUN_LIMIT);

    logic [31:0]                   r_total_len;
    logic                          r_iv;
    logic [7:0]                    r_ibyte;
    logic                          r_ilast;
    logic                          r_hdr_pend;
    logic [7:0]                    r_run_val;
    logic [15:0]                   r_run_cnt;
    logic [6:0]                    r_buf;      // first pending bit at [6]
    logic [2:0]                    r_fill;
    logic [rlwc_pkg::OBUF_W-1:0]   r_obuf;
    logic [rlwc_pkg::OCNT_W-1:0]   r_ocnt;

    logic                          out_xfer;
    logic                          proc;
    logic                          extend;
    logic                          close_a;
    logic [7:0]                    n_run_val;
    logic [15:0]                   n_run_cnt;
    rlwc_pkg::t_run_code           code_a;
    rlwc_pkg::t_run_code           code_b;
    logic [rlwc_pkg::CODE_W-1:0]   bits_a;
    logic [rlwc_pkg::CLEN_W-1:0]   len_a;
    logic [rlwc_pkg::CODE_W-1:0]   bits_b;
    logic [rlwc_pkg::CLEN_W-1:0]   len_b;
    logic [rlwc_pkg::STREAM_W-1:0] stream;
    logic [rlwc_pkg::STREAM_W-1:0] rest;
    logic [rlwc_pkg::NBITS_W-1:0]  nbits;
    logic [rlwc_pkg::NBITS_W-1:0]  off_b;
    logic [rlwc_pkg::OCNT_W-1:0]   nbytes;
    logic [rlwc_pkg::OCNT_W-1:0]   n_ocnt;
    logic [rlwc_pkg::OBUF_W-1:0]   n_obuf;

    assign o_cfg_ready   = 1'b1;
    assign out_xfer      = m_axis_tvalid && m_axis_tready;
    assign proc          = r_iv && ((r_ocnt == '0) ||
                           ((r_ocnt == rlwc_pkg::OCNT_W'(1)) && out_xfer));
    assign s_axis_tready = !r_iv || proc;

    assign m_axis_tvalid = (r_ocnt != '0);
    assign m_axis_tdata  = r_obuf[rlwc_pkg::OBUF_W-1 -: 8];
    assign m_axis_tlast  = (r_ocnt == rlwc_pkg::OCNT_W'(1));

    // Coding of the registered item against the current run state
    always_comb begin
        extend    = (r_run_cnt != '0) && (r_ibyte == r_run_val) && (r_run_cnt < LIMIT);
        close_a   = !extend && (r_run_cnt != '0);
        n_run_val = r_ibyte;
        n_run_cnt = extend ? r_run_cnt + 16'd1 : 16'd1;

        code_a = rlwc_pkg::run_code(r_run_cnt - 16'd1, r_run_val);
        code_b = rlwc_pkg::run_code(n_run_cnt - 16'd1, n_run_val);
        bits_a = close_a ? code_a.bits : '0;
        len_a  = close_a ? code_a.len  : '0;
        bits_b = r_ilast ? code_b.bits : '0;
        len_b  = r_ilast ? code_b.len  : '0;

        off_b  = rlwc_pkg::NBITS_W'(r_fill) + rlwc_pkg::NBITS_W'(len_a);
        nbits  = off_b + rlwc_pkg::NBITS_W'(len_b);
        stream = {r_buf, 57'd0}
               | ({bits_a, 24'd0} >> r_fill)
               | ({bits_b, 24'd0} >> off_b);

        // pad the final partial byte at the end of a stream
        if (r_ilast) begin
            nbytes = rlwc_pkg::OCNT_W'((nbits + rlwc_pkg::NBITS_W'(7)) >> 3);
        end else begin
            nbytes = rlwc_pkg::OCNT_W'(nbits >> 3);
        end
        rest = stream << {nbytes, 3'b000};

        if (r_hdr_pend) begin
            n_obuf = {r_total_len, stream};
            n_ocnt = nbytes + rlwc_pkg::OCNT_W'(rlwc_pkg::HDR_BYTES);
        end else begin
            n_obuf = {stream, 32'd0};
            n_ocnt = nbytes;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total_len <= '0;
            r_iv        <= 1'b0;
            r_hdr_pend  <= 1'b1;
            r_run_val   <= '0;
            r_run_cnt   <= '0;
            r_buf       <= '0;
            r_fill      <= '0;
            r_ocnt      <= '0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_total_len <= i_cfg_data;
            end

            if (s_axis_tready) begin
                r_iv <= s_axis_tvalid;
            end

            if (proc) begin
                r_ocnt <= n_ocnt;
                if (r_ilast) begin
                    // stream ends: back to the reset state
                    r_hdr_pend <= 1'b1;
                    r_run_val  <= '0;
                    r_run_cnt  <= '0;
                    r_buf      <= '0;
                    r_fill     <= '0;
                end else begin
                    r_hdr_pend <= 1'b0;
                    r_run_val  <= n_run_val;
                    r_run_cnt  <= n_run_cnt;
                    r_buf      <= rest[rlwc_pkg::STREAM_W-1 -: 7];
                    r_fill     <= nbits[2:0];
                end
            end else if (out_xfer) begin
                r_ocnt <= r_ocnt - rlwc_pkg::OCNT_W'(1);
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_ibyte <= s_axis_tdata;
            r_ilast <= s_axis_tlast;
        end
        if (proc) begin
            r_obuf <= n_obuf;
        end else if (out_xfer) begin
            r_obuf <= r_obuf << 8;
        end
    end

endmodule

### verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench for run_length_wyle_coder. A directed table covers
// reset state, extremes and alignment cases; random streams follow. Each
// output byte is checked against the in-bench coder model or typed bytes.
// ----------------------------------------------------------------------------
module tb;

    localparam int unsigned RUN_CAP   = 65535;
    localparam int          CLK_HALF  = 4;
    localparam int          RST_CYC   = 9;
    localparam int          MAX_GAP   = 18;
    localparam int          SETTLE    = 8;
    localparam int          IDLE_LIM  = 2000;
    localparam int          RAND_ITEMS = 136;
    localparam int          N_ROWS    = 12;

    typedef struct {
        logic [7:0] data;
        bit         last;
    } t_coded;

    typedef struct packed {
        bit          cfg_wr;
        logic [31:0] cfg;
        logic [7:0]  data;
        bit          last;    // applies to the final repeat only
        logic [16:0] reps;
        logic [3:0]  n_typed;
        logic [87:0] typed;   // first byte in the highest used bits
    } t_row;

    // Directed stimulus. Typed bytes are used only for single-byte streams.
    localparam t_row ROWS [N_ROWS] = '{
        '{1'b0, 32'h0000_0000, 8'hAB, 1'b1, 17'd1,     4'd6, 88'h00000000_1560},
        '{1'b1, 32'hFFFF_FFFF, 8'hFF, 1'b1, 17'd1,     4'd6, 88'hFFFFFFFF_1FE0},
        '{1'b1, 32'h0000_0010, 8'h00, 1'b0, 17'd4,     4'd0, 88'h0},
        '{1'b0, 32'h0,         8'h55, 1'b0, 17'd1,     4'd0, 88'h0},
        '{1'b0, 32'h0,         8'hAA, 1'b0, 17'd5,     4'd0, 88'h0},
        '{1'b0, 32'h0,         8'h01, 1'b0, 17'd20,    4'd0, 88'h0},
        '{1'b1, 32'h1234_5678, 8'hFE, 1'b0, 17'd24,    4'd0, 88'h0},
        '{1'b0, 32'h0,         8'h7E, 1'b0, 17'd9,     4'd0, 88'h0},
        '{1'b0, 32'h0,         8'h3C, 1'b1, 17'd1,     4'd0, 88'h0},
        '{1'b1, 32'h8000_0001, 8'h11, 1'b0, 17'd1,     4'd0, 88'h0},
        '{1'b0, 32'h0,         8'h22, 1'b1, 17'd5,     4'd0, 88'h0},
        '{1'b0, 32'h0,         8'h00, 1'b1, 17'd2,     4'd0, 88'h0}
    };

    logic        i_clk;
    logic        i_rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [31:0] cfg_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;
    logic        m_tlast;

    run_length_wyle_coder #(
        .RUN_LIMIT(RUN_CAP)
    ) uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (cfg_valid),
        .o_cfg_ready  (cfg_ready),
        .i_cfg_data   (cfg_data),
        .s_axis_tvalid(s_tvalid),
        .s_axis_tready(s_tready),
        .s_axis_tdata (s_tdata),
        .s_axis_tlast (s_tlast),
        .m_axis_tvalid(m_tvalid),
        .m_axis_tready(m_tready),
        .m_axis_tdata (m_tdata),
        .m_axis_tlast (m_tlast)
    );

    // Coder model state
    logic [31:0] total_len_m;
    bit          hdr_pend_m;
    logic [7:0]  run_val_m;
    int unsigned run_cnt_m;
    logic [6:0]  bit_buf_m;
    int unsigned bit_fill_m;
    logic [7:0]  burst[$];

    t_coded coded_q[$];
    int     errors;
    bit     tx_gaps;
    bit     rx_gaps;
    bit     rx_took;
    int     rx_hold;
    int     idle_cycles;

    initial begin
        i_clk = 1'b0;
        forever #(CLK_HALF) i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        errors++;
        if (errors <= 40) begin
            $display("mismatch @%0t: %s got %02h expected %02h", $time, what, got, want);
        end
    endtask

    task automatic clear_stream();
        hdr_pend_m = 1'b1;
        run_val_m  = '0;
        run_cnt_m  = 0;
        bit_buf_m  = '0;
        bit_fill_m = 0;
    endtask

    task automatic emit_bit(input bit b);
        logic [7:0] acc;
        acc = {bit_buf_m, b};
        if (bit_fill_m == 7) begin
            burst.push_back(acc);
            bit_buf_m  = '0;
            bit_fill_m = 0;
        end else begin
            bit_buf_m  = acc[6:0];
            bit_fill_m++;
        end
    endtask

    // Write the Wyle code of the open run and its byte value.
    task automatic close_run();
        logic [15:0] a;
        logic [13:0] q;
        int          len;
        if (run_cnt_m == 0) begin
            return;
        end
        a   = 16'(run_cnt_m - 1);
        q   = a[15:2];
        len = 0;
        while (q != 0) begin
            q = q >> 1;
            len++;
        end
        repeat (len) emit_bit(1'b1);
        emit_bit(1'b0);
        for (int i = 0; i < len + 2; i++) begin
            emit_bit(a[i]);
        end
        for (int i = 7; i >= 0; i--) begin
            emit_bit(run_val_m[i]);
        end
        run_cnt_m = 0;
    endtask

    task automatic code_byte(input logic [7:0] d, input bit l);
        burst.delete();
        if (hdr_pend_m) begin
            for (int k = 3; k >= 0; k--) begin
                burst.push_back(total_len_m[8*k +: 8]);
            end
            hdr_pend_m = 1'b0;
        end
        if (run_cnt_m != 0 && d == run_val_m && run_cnt_m < RUN_CAP) begin
            run_cnt_m++;
        end else begin
            close_run();
            run_val_m = d;
            run_cnt_m = 1;
        end
        if (l) begin
            close_run();
            while (bit_fill_m != 0) emit_bit(1'b0);
            clear_stream();
        end
    endtask

    task automatic push_input(input logic [7:0] d, input bit l, input int n_typed,
                              input logic [87:0] typed);
        int gap;
        gap = tx_gaps ? $urandom_range(0, MAX_GAP) : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        s_tlast  <= l;
        do @(posedge i_clk); while (!s_tready);
        code_byte(d, l);
        if (n_typed > 0) begin
            burst.delete();
            for (int k = 0; k < n_typed; k++) begin
                burst.push_back(8'(typed >> (8 * (n_typed - 1 - k))));
            end
        end
        foreach (burst[k]) begin
            coded_q.push_back('{data: burst[k], last: (k == burst.size() - 1)});
        end
    endtask

    // Hold off input until every expected byte is out and the block is quiet.
    task automatic drain();
        @(negedge i_clk);
        s_tvalid <= 1'b0;
        while (coded_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_length(input logic [31:0] v);
        @(negedge i_clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge i_clk); while (!cfg_ready);
        total_len_m = v;
        @(negedge i_clk);
        cfg_valid <= 1'b0;
    endtask

    // Output side: draw a stall per transaction.
    always @(negedge i_clk) begin
        if (rx_took) begin
            rx_took = 1'b0;
            rx_hold = rx_gaps ? $urandom_range(0, MAX_GAP) : 0;
        end
        if (rx_hold > 0) begin
            rx_hold--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_coded want;
        if (i_rst_n && m_tvalid && m_tready) begin
            rx_took = 1'b1;
            if (coded_q.size() == 0) begin
                report_mismatch("unexpected byte", m_tdata, 8'h00);
            end else begin
                want = coded_q.pop_front();
                if (m_tdata !== want.data) begin
                    report_mismatch("out_byte", m_tdata, want.data);
                end
                if (m_tlast !== want.last) begin
                    report_mismatch("out_last", 8'(m_tlast), 8'(want.last));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= IDLE_LIM) begin
            $display("timeout: no transaction for %0d cycles", IDLE_LIM);
            $display("FAILED: results differ");
            $finish;
        end
    end

    initial begin
        int         sent;
        int         len;
        int         pick;
        int         run_n;
        logic [7:0] d;
        logic [7:0] prev;
        bit         l;
        i_rst_n     = 1'b0;
        cfg_valid   = 1'b0;
        cfg_data    = '0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tlast     = 1'b0;
        m_tready    = 1'b0;
        errors      = 0;
        rx_took     = 1'b0;
        rx_hold     = 0;
        idle_cycles = 0;
        tx_gaps     = 1'b1;
        rx_gaps     = 1'b1;
        total_len_m = '0;
        clear_stream();

        repeat (RST_CYC) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int r = 0; r < N_ROWS; r++) begin
            if (ROWS[r].cfg_wr) begin
                drain();
                write_length(ROWS[r].cfg);
            end
            // long runs go through with no stalls
            tx_gaps = (ROWS[r].reps <= 16);
            rx_gaps = tx_gaps;
            for (int n = 0; n < int'(ROWS[r].reps); n++) begin
                l = ROWS[r].last && (n == int'(ROWS[r].reps) - 1);
                push_input(ROWS[r].data, l, int'(ROWS[r].n_typed), ROWS[r].typed);
            end
        end

        drain();
        write_length(32'h0000_0000);

        sent = 0;
        prev = '0;
        while (sent < RAND_ITEMS) begin
            tx_gaps = ($urandom_range(0, 9) < 7);
            rx_gaps = ($urandom_range(0, 9) < 7);
            if ($urandom_range(0, 3) == 0) begin
                drain();
                pick = $urandom_range(0, 3);
                case (pick)
                    0:       write_length(32'h0000_0000);
                    1:       write_length(32'hFFFF_FFFF);
                    2:       write_length(32'($urandom_range(1, 64)));
                    default: write_length($urandom);
                endcase
            end
            len = $urandom_range(1, 16);
            for (int i = 0; i < len; i++) begin
                if (i > 0 && $urandom_range(0, 99) < 55) begin
                    d = prev;
                end else begin
                    d = 8'($urandom_range(0, 255));
                end
                if ($urandom_range(0, 39) == 0) begin
                    run_n = $urandom_range(8, 24);
                    repeat (run_n) push_input(d, 1'b0, 0, '0);
                    sent += run_n;
                end
                // now and then leave the stream open into the next one
                l = (i == len - 1) && ($urandom_range(0, 9) != 0);
                push_input(d, l, 0, '0);
                prev = d;
                sent++;
            end
        end
        push_input(8'($urandom_range(0, 255)), 1'b1, 0, '0);

        drain();
        if (errors == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
